/* hw/rtl/gbha_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbha_pkg: shared types and constants of the group-by aggregator
// field widths, aggregate kinds, status codes and per-cell control struct
// ---------------------------------------------------------------------------
package gbha_pkg;
	localparam int DEF_TABLE_SLOTS = 256;
	localparam int DEF_NUM_COLUMNS = 4;
	localparam int DEF_VALUE_BITS  = 32;
	localparam int KEY_BITS  = 32;
	localparam int OUT_BITS  = 32;
	localparam int KIND_BITS = 3;
	localparam int CFG_BITS  = 3;
	localparam int CFG_IDX_BITS = 3;
	localparam int MAX_COLS  = 4;

	localparam logic [2:0] KIND_COUNT_STAR = 3'd0;
	localparam logic [2:0] KIND_COUNT      = 3'd1;
	localparam logic [2:0] KIND_SUM        = 3'd2;
	localparam logic [2:0] KIND_MIN        = 3'd3;
	localparam logic [2:0] KIND_MAX        = 3'd4;
	localparam logic [2:0] KIND_AVG        = 3'd5;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_GROUP = 2'd2;
	localparam logic [1:0] ST_NONE  = 2'd3;

	localparam logic [2:0] CFG_KIND0 = 3'd0;
	localparam logic [2:0] CFG_COLS  = 3'd4;

	// command broadcast down the cell chain
	typedef struct packed {
		logic                do_insert;  // start or combine at matching cell
		logic                do_clear;
		logic                do_read;    // read first used cell at or after cursor
	} cell_cmd_t;

	// per-column result of one cell
	typedef struct packed {
		logic [OUT_BITS-1:0] val;
		logic                nul;
	} col_out_t;
endpackage

/* hw/rtl/gbha_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbha_in_if / gbha_out_if: valid/ready channels of the aggregator
// input row beats and result beats
// ---------------------------------------------------------------------------
interface gbha_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] group_key;
	logic signed [31:0] in_val0, in_val1, in_val2, in_val3;
	logic        in_null0, in_null1, in_null2, in_null3;
	modport source(output valid, mode, group_key, in_val0, in_val1, in_val2, in_val3,
		in_null0, in_null1, in_null2, in_null3, input ready);
	modport sink(input valid, mode, group_key, in_val0, in_val1, in_val2, in_val3,
		in_null0, in_null1, in_null2, in_null3, output ready);
endinterface

interface gbha_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] out_key;
	logic signed [31:0] out_val0, out_val1, out_val2, out_val3;
	logic        out_null0, out_null1, out_null2, out_null3;
	modport source(output valid, status, out_key, out_val0, out_val1, out_val2, out_val3,
		out_null0, out_null1, out_null2, out_null3, input ready);
	modport sink(input valid, status, out_key, out_val0, out_val1, out_val2, out_val3,
		out_null0, out_null1, out_null2, out_null3, output ready);
endinterface

/* hw/rtl/gbha_divider.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbha_divider: restoring signed divider, one quotient bit a cycle
// truncates toward zero, used for the avg result
// ---------------------------------------------------------------------------
module gbha_divider #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,   // signed
	input  logic [W-1:0] divisor,    // unsigned, nonzero
	output logic         busy,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] rem_q, quo_q, div_q;
	logic         neg_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]   trial;
	logic [W-1:0] mag;

	assign mag   = dividend[W-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, div_q};
	assign busy  = (cnt_q != '0);
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			div_q <= divisor;
			neg_q <= dividend[W-1];
		end else if (busy) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

/* hw/rtl/gbha_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbha_cell: one table slot with its key and per-column running state
// matches its key, ripples free and cursor priority, combines in place
// ---------------------------------------------------------------------------
module gbha_cell #(
	parameter int NUM_COLUMNS = 4,
	parameter int VALUE_BITS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gbha_pkg::cell_cmd_t          cmd,
	input  logic [31:0]                  key,
	input  logic [NUM_COLUMNS-1:0][VALUE_BITS-1:0] vals,
	input  logic [NUM_COLUMNS-1:0]       nulls,
	input  logic [NUM_COLUMNS-1:0][2:0]  kinds,
	input  logic [NUM_COLUMNS-1:0]       act,
	input  logic                         any_hit,    // some cell holds the key
	input  logic                         free_in,    // a free cell sits before
	output logic                         free_out,
	input  logic                         at_cursor,  // this cell is at or past the cursor
	input  logic                         read_in,    // a used cell already picked
	output logic                         read_out,
	output logic                         hit,
	output logic                         pick,       // this cell chosen for the read
	output logic [31:0]                  key_q_o,
	output logic [NUM_COLUMNS-1:0][VALUE_BITS-1:0] val_o,
	output logic [NUM_COLUMNS-1:0]       nul_o,
	output logic [NUM_COLUMNS-1:0][VALUE_BITS-1:0] cnt_o
);
	import gbha_pkg::*;
	logic used_q;
	logic [31:0] key_q;
	logic [NUM_COLUMNS-1:0][VALUE_BITS-1:0] val_q, cnt_q;
	logic [NUM_COLUMNS-1:0] nul_q;
	logic take;

	assign hit      = used_q && (key_q == key);
	assign take     = !used_q && !free_in && !any_hit;
	assign free_out = free_in || !used_q;
	assign pick     = used_q && at_cursor && !read_in;
	assign read_out = read_in || (used_q && at_cursor);
	assign key_q_o  = key_q;
	assign val_o    = val_q;
	assign nul_o    = nul_q;
	assign cnt_o    = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (cmd.do_clear) begin
			used_q <= 1'b0;
		end else if (cmd.do_insert && take) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_insert && take) begin
			key_q <= key;
			for (int c = 0; c < NUM_COLUMNS; c++) begin
				val_q[c] <= '0;
				nul_q[c] <= 1'b1;
				cnt_q[c] <= '0;
				if (act[c]) begin
					case (kinds[c])
						KIND_COUNT_STAR: begin
							val_q[c] <= VALUE_BITS'(1);
							nul_q[c] <= 1'b0;
						end
						KIND_COUNT: begin
							val_q[c] <= VALUE_BITS'(!nulls[c]);
							nul_q[c] <= 1'b0;
						end
						KIND_SUM, KIND_MIN, KIND_MAX, KIND_AVG: begin
							if (!nulls[c]) begin
								val_q[c] <= vals[c];
								nul_q[c] <= 1'b0;
								cnt_q[c] <= VALUE_BITS'(1);
							end
						end
						default: ;
					endcase
				end
			end
		end else if (cmd.do_insert && hit) begin
			for (int c = 0; c < NUM_COLUMNS; c++) begin
				if (act[c]) begin
					case (kinds[c])
						KIND_COUNT_STAR: begin
							val_q[c] <= val_q[c] + 1'b1;
							nul_q[c] <= 1'b0;
						end
						KIND_COUNT: begin
							if (!nulls[c]) val_q[c] <= val_q[c] + 1'b1;
							nul_q[c] <= 1'b0;
						end
						KIND_SUM, KIND_MIN, KIND_MAX, KIND_AVG: begin
							if (!nulls[c]) begin
								if (nul_q[c]) begin
									val_q[c] <= vals[c];
									nul_q[c] <= 1'b0;
									if (kinds[c] == KIND_AVG) cnt_q[c] <= VALUE_BITS'(1);
								end else if (kinds[c] == KIND_SUM) begin
									val_q[c] <= val_q[c] + vals[c];
								end else if (kinds[c] == KIND_AVG) begin
									val_q[c] <= val_q[c] + vals[c];
									cnt_q[c] <= cnt_q[c] + 1'b1;
								end else if (kinds[c] == KIND_MIN) begin
									if ($signed(vals[c]) < $signed(val_q[c]))
										val_q[c] <= vals[c];
								end else begin
									if ($signed(vals[c]) > $signed(val_q[c]))
										val_q[c] <= vals[c];
								end
							end
						end
						default: ;
					endcase
				end
			end
		end
	end
endmodule

/* hw/rtl/group_by_hash_aggregator_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// group_by_hash_aggregator_top: group-by aggregation table
// row of slot cells with per-column running aggregates and a shared divider
// ---------------------------------------------------------------------------
// Each slot is a cell holding its key and per-column state; insert, clear and
// lookup act on all cells at once, with free-slot and read-cursor priority
// rippling along the row. An insert or clear beat goes through accept, row
// update and result; the result beat is held until ready. A read does the same
// when no active column is avg. When any active column is avg, the read then
// visits each column in turn, and each avg column that is divided (non-null
// with a nonzero count) gets its quotient from one shared bit-serial divider,
// run once per such column. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module group_by_hash_aggregator_top #(
	parameter int TABLE_SLOTS = gbha_pkg::DEF_TABLE_SLOTS,
	parameter int NUM_COLUMNS = gbha_pkg::DEF_NUM_COLUMNS,
	parameter int VALUE_BITS  = gbha_pkg::DEF_VALUE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	gbha_in_if.sink   in_ch,
	gbha_out_if.source out_ch,
	input  logic                          cfg_we,
	input  logic [gbha_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [gbha_pkg::CFG_BITS-1:0]     cfg_data
);
	import gbha_pkg::*;
	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int CUR_W = SW + 1;
	localparam int CW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_DIV  = 5'b00100,
		S_WAIT = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;
	state_t state_q;

	// configuration
	logic [MAX_COLS-1:0][2:0] kind_q;
	logic [2:0] cols_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
			cols_q <= 3'd4;
		end else if (cfg_we) begin
			if (cfg_index < CFG_COLS) kind_q[cfg_index[1:0]] <= cfg_data;
			else if (cfg_index == CFG_COLS) cols_q <= cfg_data;
		end
	end

	logic [NUM_COLUMNS-1:0][2:0] kinds;
	logic [NUM_COLUMNS-1:0] act;
	always_comb begin
		for (int c = 0; c < NUM_COLUMNS; c++) begin
			kinds[c] = kind_q[c];
			act[c] = (32'(c) < 32'(cols_q));
		end
	end

	// input row capture
	logic [1:0] mode_q;
	logic [31:0] key_q;
	logic [NUM_COLUMNS-1:0][VALUE_BITS-1:0] vals_q;
	logic [NUM_COLUMNS-1:0] nulls_q;
	logic [MAX_COLS-1:0][31:0] in_v;
	logic [MAX_COLS-1:0] in_n;
	assign in_v = {in_ch.in_val3, in_ch.in_val2, in_ch.in_val1, in_ch.in_val0};
	assign in_n = {in_ch.in_null3, in_ch.in_null2, in_ch.in_null1, in_ch.in_null0};
	assign in_ch.ready = (state_q == S_IDLE);
	wire in_beat = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk) begin
		if (in_beat) begin
			mode_q <= in_ch.mode;
			key_q  <= in_ch.group_key;
			for (int c = 0; c < NUM_COLUMNS; c++) begin
				vals_q[c]  <= in_v[c][VALUE_BITS-1:0];
				nulls_q[c] <= in_n[c];
			end
		end
	end

	// cell row
	logic [CUR_W-1:0] cursor_q;
	cell_cmd_t cmd;
	logic [TABLE_SLOTS:0] free_ch, read_ch;
	logic [TABLE_SLOTS-1:0] hits, picks;
	logic [TABLE_SLOTS-1:0][31:0] ckey;
	logic [TABLE_SLOTS-1:0][NUM_COLUMNS-1:0][VALUE_BITS-1:0] cval, ccnt;
	logic [TABLE_SLOTS-1:0][NUM_COLUMNS-1:0] cnul;
	logic any_hit;
	logic exec;
	assign exec = (state_q == S_EXEC);
	assign cmd.do_insert = exec && (mode_q == MODE_INSERT);
	assign cmd.do_clear  = exec && (mode_q == MODE_CLEAR);
	assign cmd.do_read   = exec && (mode_q == MODE_READ);
	assign any_hit = |hits;
	assign free_ch[0] = 1'b0;
	assign read_ch[0] = 1'b0;

	for (genvar s = 0; s < TABLE_SLOTS; s++) begin : g_cell
		gbha_cell #(.NUM_COLUMNS(NUM_COLUMNS), .VALUE_BITS(VALUE_BITS)) u_cell (
			.clk, .arst_n, .cmd, .key(key_q), .vals(vals_q), .nulls(nulls_q),
			.kinds, .act, .any_hit,
			.free_in(free_ch[s]), .free_out(free_ch[s+1]),
			.at_cursor(CUR_W'(s) >= cursor_q),
			.read_in(read_ch[s]), .read_out(read_ch[s+1]),
			.hit(hits[s]), .pick(picks[s]), .key_q_o(ckey[s]),
			.val_o(cval[s]), .nul_o(cnul[s]), .cnt_o(ccnt[s])
		);
	end

	// capture of the picked slot (index from a loop over the one-hot picks)
	logic [SW-1:0] pick_idx;
	always_comb begin
		pick_idx = '0;
		for (int s = 0; s < TABLE_SLOTS; s++)
			if (picks[s]) pick_idx = SW'(s);
	end

	logic [1:0] st_q;
	logic [31:0] okey_q;
	logic [NUM_COLUMNS-1:0][VALUE_BITS-1:0] rv_q, rc_q;
	logic [NUM_COLUMNS-1:0] rn_q;
	logic [MAX_COLS-1:0][OUT_BITS-1:0] ov_q;
	logic [MAX_COLS-1:0] on_q;
	logic [CW-1:0] col_q;
	logic need_div;
	logic [1:0] st_d;
	logic [31:0] okey_d;
	logic [MAX_COLS-1:0][OUT_BITS-1:0] ov_d;
	logic [MAX_COLS-1:0] on_d;

	always_comb begin
		need_div = 1'b0;
		for (int c = 0; c < NUM_COLUMNS; c++)
			if (act[c] && kinds[c] == KIND_AVG) need_div = 1'b1;
	end

	// result of the row update, avg quotients filled in later by the divider
	always_comb begin
		st_d = ST_OK;
		okey_d = '0;
		ov_d = '0;
		on_d = '0;
		if (mode_q == MODE_INSERT && !any_hit && free_ch[TABLE_SLOTS] == 1'b0)
			st_d = ST_FULL;
		if (mode_q == MODE_READ) begin
			if (read_ch[TABLE_SLOTS]) begin
				st_d = ST_GROUP;
				okey_d = ckey[pick_idx];
				for (int c = 0; c < NUM_COLUMNS; c++) begin
					if (act[c]) begin
						case (kinds[c])
							KIND_COUNT_STAR, KIND_COUNT: begin
								ov_d[c] = OUT_BITS'($signed(cval[pick_idx][c]));
							end
							KIND_SUM, KIND_MIN, KIND_MAX: begin
								on_d[c] = cnul[pick_idx][c];
								if (!cnul[pick_idx][c])
									ov_d[c] = OUT_BITS'($signed(cval[pick_idx][c]));
							end
							KIND_AVG: begin
								on_d[c] = cnul[pick_idx][c] || ccnt[pick_idx][c] == '0;
							end
							default: on_d[c] = 1'b1;
						endcase
					end
				end
			end else begin
				st_d = ST_NONE;
			end
		end
	end

	// divider
	logic div_start, div_busy;
	logic [VALUE_BITS-1:0] div_q_o;
	gbha_divider #(.W(VALUE_BITS)) u_div (
		.clk, .arst_n, .start(div_start), .dividend(rv_q[col_q]),
		.divisor(rc_q[col_q]), .busy(div_busy), .quotient(div_q_o)
	);
	wire col_avg = act[col_q] && kinds[col_q] == KIND_AVG && !rn_q[col_q]
		&& rc_q[col_q] != '0;
	assign div_start = (state_q == S_DIV) && col_avg;
	wire last_col = (32'(col_q) == NUM_COLUMNS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_beat) state_q <= S_EXEC;
				S_EXEC: begin
					if (mode_q == MODE_CLEAR) cursor_q <= '0;
					if (mode_q == MODE_READ) begin
						if (read_ch[TABLE_SLOTS]) begin
							cursor_q <= CUR_W'(pick_idx) + 1'b1;
							state_q <= need_div ? S_DIV : S_OUT;
						end else begin
							cursor_q <= CUR_W'(TABLE_SLOTS);
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: state_q <= col_avg ? S_WAIT : (last_col ? S_OUT : S_DIV);
				S_WAIT: if (!div_busy) state_q <= last_col ? S_OUT : S_DIV;
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_EXEC: begin
				st_q <= st_d;
				okey_q <= okey_d;
				ov_q <= ov_d;
				on_q <= on_d;
				col_q <= '0;
				rv_q <= cval[pick_idx];
				rc_q <= ccnt[pick_idx];
				rn_q <= cnul[pick_idx];
			end
			S_DIV: if (!col_avg && !last_col) col_q <= col_q + 1'b1;
			S_WAIT: if (!div_busy) begin
				ov_q[col_q] <= OUT_BITS'($signed(div_q_o));
				if (!last_col) col_q <= col_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign out_ch.valid  = (state_q == S_OUT);
	assign out_ch.status = st_q;
	assign out_ch.out_key = okey_q;
	assign out_ch.out_val0 = ov_q[0];
	assign out_ch.out_val1 = ov_q[1];
	assign out_ch.out_val2 = ov_q[2];
	assign out_ch.out_val3 = ov_q[3];
	assign out_ch.out_null0 = on_q[0];
	assign out_ch.out_null1 = on_q[1];
	assign out_ch.out_null2 = on_q[2];
	assign out_ch.out_null3 = on_q[3];

	// at most one cell holds a key, at most one is picked
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> $onehot0(hits)) else $error("key held twice");
	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		exec |-> $onehot0(picks)) else $error("two slots picked");
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CUR_W'(TABLE_SLOTS)) else $error("cursor past end");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("accepted while result pending");
endmodule
